// ===== hdl/ofsl_pkg.sv =====
package ofsl_pkg;

   // Width of the memory address space that write addresses are wrapped to.
   localparam int ADDR_WIDTH = 16;
   localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_WIDTH) - 32'd1);

   // Section header words.
   localparam logic [15:0] HDR_CODE     = 16'hCADE;
   localparam logic [15:0] HDR_DATA     = 16'hDADA;
   localparam logic [15:0] HDR_SYMBOL   = 16'hC3B7;
   localparam logic [15:0] HDR_FILENAME = 16'hF17E;
   localparam logic [15:0] HDR_LINE     = 16'h715E;

   // A line-number section carries three words after its header.
   localparam logic [15:0] LINE_SKIP_BYTES = 16'd6;

   // Command queue between the parser and the response stage.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_HDR_HI  = 4'd0,
      PH_HDR_LO  = 4'd1,
      PH_ADDR_HI = 4'd2,
      PH_ADDR_LO = 4'd3,
      PH_CNT_HI  = 4'd4,
      PH_CNT_LO  = 4'd5,
      PH_WORD_HI = 4'd6,
      PH_WORD_LO = 4'd7,
      PH_SKIP    = 4'd8
   } parse_phase_type;

   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_SYMBOL   = 2'd1,
      KIND_FILENAME = 2'd2,
      KIND_LINE     = 2'd3
   } section_kind_type;

   typedef enum logic {
      RESULT_WRITE = 1'b0,
      RESULT_ERROR = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type kind;
      logic [15:0]     address;
      logic [15:0]     data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

endpackage

// ===== hdl/ofsl_if.sv =====
interface ofsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface ofsl_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] write_address;
   logic [15:0] write_data;

   modport source (output valid, output result_kind, output write_address,
                   output write_data, input ready);
   modport sink (input valid, input result_kind, input write_address,
                 input write_data, output ready);
endinterface

// ===== hdl/ofsl_parser.sv =====
module ofsl_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            data_byte,
   output ofsl_pkg::cmd_slot_type cmd_push
);
   import ofsl_pkg::*;

   parse_phase_type  phase_ff, phase_in;
   section_kind_type kind_ff, kind_in;
   logic [7:0]       hold_ff, hold_in;
   logic [15:0]      addr_ff, addr_in;
   logic [15:0]      count_ff, count_in;
   logic             halted_ff, halted_in;

   logic [15:0] word;
   logic        active;
   logic        known_header;

   assign word   = {hold_ff, data_byte};
   assign active = byte_accept && !halted_ff;
   assign known_header = word inside {HDR_CODE, HDR_DATA, HDR_SYMBOL, HDR_FILENAME, HDR_LINE};

   // Next state of the section grammar.
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      hold_in   = hold_ff;
      addr_in   = addr_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      if (active) begin
         case (phase_ff)
            PH_HDR_LO: begin
               if (word inside {HDR_CODE, HDR_DATA}) begin
                  kind_in  = KIND_LOAD;
                  phase_in = PH_ADDR_HI;
               end else if (word == HDR_SYMBOL) begin
                  kind_in  = KIND_SYMBOL;
                  phase_in = PH_ADDR_HI;
               end else if (word == HDR_FILENAME) begin
                  kind_in  = KIND_FILENAME;
                  phase_in = PH_CNT_HI;
               end else if (word == HDR_LINE) begin
                  kind_in  = KIND_LINE;
                  count_in = LINE_SKIP_BYTES;
                  phase_in = PH_SKIP;
               end else begin
                  halted_in = 1'b1;
                  phase_in  = PH_HDR_HI;
               end
            end
            PH_ADDR_HI: begin
               hold_in  = data_byte;
               phase_in = PH_ADDR_LO;
            end
            PH_CNT_HI: begin
               hold_in  = data_byte;
               phase_in = PH_CNT_LO;
            end
            PH_WORD_HI: begin
               hold_in  = data_byte;
               phase_in = PH_WORD_LO;
            end
            PH_ADDR_LO: begin
               if (kind_ff == KIND_LOAD) begin
                  addr_in = word;
               end
               phase_in = PH_CNT_HI;
            end
            PH_CNT_LO: begin
               count_in = word;
               if (word == 16'd0) begin
                  phase_in = PH_HDR_HI;
               end else if (kind_ff == KIND_LOAD) begin
                  phase_in = PH_WORD_HI;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_WORD_LO: begin
               addr_in  = addr_ff + 16'd1;
               count_in = count_ff - 16'd1;
               phase_in = (count_ff == 16'd1) ? PH_HDR_HI : PH_WORD_HI;
            end
            PH_SKIP: begin
               count_in = count_ff - 16'd1;
               if (count_ff == 16'd1) begin
                  phase_in = PH_HDR_HI;
               end
            end
            default: begin
               hold_in  = data_byte;
               phase_in = PH_HDR_LO;
            end
         endcase
      end
   end

   // Command produced by the current byte, if any.
   always_comb begin
      cmd_push.valid       = 1'b0;
      cmd_push.cmd.kind    = RESULT_WRITE;
      cmd_push.cmd.address = addr_ff & ADDR_MASK;
      cmd_push.cmd.data    = word;
      case (phase_ff)
         PH_WORD_LO: begin
            cmd_push.valid = active;
         end
         PH_HDR_LO: begin
            if (!known_header) begin
               cmd_push.valid       = active;
               cmd_push.cmd.kind    = RESULT_ERROR;
               cmd_push.cmd.address = 16'd0;
               cmd_push.cmd.data    = 16'd0;
            end
         end
         default: begin
            cmd_push.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR_HI;
         kind_ff   <= KIND_LOAD;
         hold_ff   <= 8'd0;
         addr_ff   <= 16'd0;
         count_ff  <= 16'd0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         hold_ff   <= hold_in;
         addr_ff   <= addr_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

`ifndef SYNTHESIS
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !cmd_push.valid)
      else $error("parser produced a command after a bad header");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      cmd_push.valid && cmd_push.cmd.kind == RESULT_ERROR |=> halted_ff)
      else $error("bad header did not halt the parser");

   a_write_advances: assert property (@(posedge clock) disable iff (reset)
      cmd_push.valid && cmd_push.cmd.kind == RESULT_WRITE
      |=> addr_ff == $past(addr_ff) + 16'd1)
      else $error("load address did not advance after a write");
`endif

endmodule

// ===== hdl/ofsl_queue.sv =====
module ofsl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ofsl_pkg::cmd_slot_type cmd_push,
   input  logic                   pop,
   output ofsl_pkg::cmd_slot_type head,
   output logic                   space
);
   import ofsl_pkg::*;

   cmd_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                         push_en;
   logic                         pop_en;

   assign space    = count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign push_en  = cmd_push.valid && space;
   assign pop_en   = pop && (count_ff != '0);
   assign head.valid = count_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop_en ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= cmd_push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("command queue overflowed");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == rd_ptr_ff + QUEUE_PTR_WIDTH'(count_ff))
      else $error("queue pointers disagree with the fill count");

   a_head_stable: assert property (@(posedge clock) disable iff (reset)
      head.valid && !pop |=> $stable(head.cmd))
      else $error("waiting queue head changed before it was taken");
`endif

endmodule

// ===== hdl/ofsl_emitter.sv =====
module ofsl_emitter (
   input  logic                   clock,
   input  logic                   reset,
   input  ofsl_pkg::cmd_slot_type head,
   output logic                   pop,
   ofsl_rsp_if.source             rsp_chan
);
   import ofsl_pkg::*;

   logic    out_valid_ff, out_valid_in;
   cmd_type out_cmd_ff, out_cmd_in;
   logic    slot_free;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign pop       = head.valid && slot_free;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cmd_in   = out_cmd_ff;
      if (slot_free) begin
         out_valid_in = head.valid;
         out_cmd_in   = head.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cmd_ff <= out_cmd_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_cmd_ff.kind;
   assign rsp_chan.write_address = out_cmd_ff.address;
   assign rsp_chan.write_data    = out_cmd_ff.data;

endmodule

// ===== hdl/object_file_section_loader_core.sv =====
// Object file section loader.
// The req_chan channel takes the raw object file one byte per transfer, in
// file order. The rsp_chan channel gives one transfer for each loaded code or
// data word (result_kind 0, with its word address and value) and a single
// transfer with result_kind 1 when a section header is not recognized; after
// that error every byte is taken and dropped until reset.
// A byte that completes a payload word is written into the command queue
// as it transfers, then passes through the output register to rsp_chan.
// The block takes one byte every cycle while the command queue has space:
// the parser handles each byte in one state step, and a four-entry command
// queue plus an output register carry results to the receiver.
// When the receiver stalls, results collect in the queue; the byte channel
// stays ready until the queue is full and is ready again in the cycle after
// an entry leaves it.
// Synchronous reset returns the parser to wait for a section header, clears
// the error halt and empties the queue and the output register.
module object_file_section_loader_core (
   input  logic       clock,
   input  logic       reset,
   ofsl_req_if.sink   req_chan,
   ofsl_rsp_if.source rsp_chan
);
   import ofsl_pkg::*;

   cmd_slot_type cmd_push;
   cmd_slot_type head;
   logic         pop;
   logic         space;
   logic         byte_accept;

   // Bytes are taken whenever the queue can hold the command a byte may make.
   assign req_chan.ready = space;
   assign byte_accept    = req_chan.valid && space;

   // Front end: section grammar, word assembly and address tracking.
   ofsl_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_chan.data_byte),
      .cmd_push    (cmd_push)
   );

   // Decouples the parser from stalls on the result channel.
   ofsl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd_push (cmd_push),
      .pop      (pop),
      .head     (head),
      .space    (space)
   );

   // Back end: registered result channel.
   ofsl_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== dv/tb_object_file_section_loader_core.sv =====
`timescale 1ns / 100ps

module tb_object_file_section_loader_core;
   import ofsl_pkg::*;

   // Tracks the loader's parse of the byte stream and holds the writes (and the one
   // error) that the block owes the receiver, oldest first.
   class section_loader_tracker;
      parse_phase_type  parse_state;
      section_kind_type section;
      logic [7:0]       held_byte;
      logic [15:0]      next_address;
      logic [15:0]      words_left;
      bit               halted;
      cmd_type          expected_writes[$];
      int               mismatches;

      function new();
         parse_state  = PH_HDR_HI;
         section      = KIND_LOAD;
         held_byte    = '0;
         next_address = '0;
         words_left   = '0;
         halted       = 1'b0;
         mismatches   = 0;
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      // Advances the parse by one accepted byte and queues any result it causes.
      function void note_byte(logic [7:0] file_byte);
         logic [15:0] word;
         cmd_type     entry;
         word = {held_byte, file_byte};
         if (halted) return;
         case (parse_state)
            PH_HDR_LO: begin
               if (word == HDR_CODE || word == HDR_DATA) begin
                  section     = KIND_LOAD;
                  parse_state = PH_ADDR_HI;
               end else if (word == HDR_SYMBOL) begin
                  section     = KIND_SYMBOL;
                  parse_state = PH_ADDR_HI;
               end else if (word == HDR_FILENAME) begin
                  section     = KIND_FILENAME;
                  parse_state = PH_CNT_HI;
               end else if (word == HDR_LINE) begin
                  section     = KIND_LINE;
                  words_left  = LINE_SKIP_BYTES;
                  parse_state = PH_SKIP;
               end else begin
                  halted        = 1'b1;
                  parse_state   = PH_HDR_HI;
                  entry.kind    = RESULT_ERROR;
                  entry.address = '0;
                  entry.data    = '0;
                  expected_writes.push_back(entry);
               end
            end
            PH_ADDR_HI: begin
               held_byte   = file_byte;
               parse_state = PH_ADDR_LO;
            end
            PH_CNT_HI: begin
               held_byte   = file_byte;
               parse_state = PH_CNT_LO;
            end
            PH_WORD_HI: begin
               held_byte   = file_byte;
               parse_state = PH_WORD_LO;
            end
            PH_ADDR_LO: begin
               // A symbol section's address is read and dropped.
               if (section == KIND_LOAD) next_address = word;
               parse_state = PH_CNT_HI;
            end
            PH_CNT_LO: begin
               words_left = word;
               if (word == 16'd0) parse_state = PH_HDR_HI;
               else if (section == KIND_LOAD) parse_state = PH_WORD_HI;
               else parse_state = PH_SKIP;
            end
            PH_WORD_LO: begin
               entry.kind    = RESULT_WRITE;
               entry.address = next_address & ADDR_MASK;
               entry.data    = word;
               expected_writes.push_back(entry);
               next_address = next_address + 16'd1;
               words_left   = words_left - 16'd1;
               parse_state  = (words_left == 16'd0) ? PH_HDR_HI : PH_WORD_HI;
            end
            PH_SKIP: begin
               words_left = words_left - 16'd1;
               if (words_left == 16'd0) parse_state = PH_HDR_HI;
            end
            default: begin
               held_byte   = file_byte;
               parse_state = PH_HDR_LO;
            end
         endcase
      endfunction

      // Compares one accepted result with the oldest queued one, field by field.
      function void check_result(logic kind, logic [15:0] address, logic [15:0] data);
         cmd_type entry;
         if (expected_writes.size() == 0) begin
            $display("%0t: result with nothing pending: kind %0d address %h data %h",
                     $time, kind, address, data);
            mismatches++;
            return;
         end
         entry = expected_writes.pop_front();
         if (logic'(entry.kind) !== kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, entry.kind, kind);
            mismatches++;
         end
         if (entry.address !== address) begin
            $display("%0t: write_address expected %h actual %h", $time, entry.address,
                     address);
            mismatches++;
         end
         if (entry.data !== data) begin
            $display("%0t: write_data expected %h actual %h", $time, entry.data, data);
            mismatches++;
         end
      endfunction
   endclass

   // Roughly this many bytes make up the random part of the file; it is split
   // evenly over the four idling phases.
   localparam int RANDOM_BYTES = 950;
   // Far above the slowest correct run.
   localparam int CYCLE_LIMIT  = 400000;
   // The output path is a four-entry queue plus an output register, so a short
   // wait after the last expected result exposes any stray transfer.
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset;

   ofsl_req_if req_chan();
   ofsl_rsp_if rsp_chan();

   object_file_section_loader_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   section_loader_tracker board = new();

   // Chance, in percent, that the byte source holds off or the receiver stalls in a
   // given cycle. The stimulus process moves these from one phase to the next.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int bytes_sent     = 0;
   int cycle_count    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A hang anywhere in the flow ends here, and so does an
   // expected result that never shows up.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("object_file_section_loader_core verification failed");
         $finish;
      end
   end

   // The receiver's ready is redrawn every cycle from the current stall rate.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Both channels are sampled at the clock edge, before this edge's driven
   // values land. An accepted byte is noted first, so a result that transfers in
   // the same cycle as its byte would still find its expectation waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_byte(req_chan.data_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result(rsp_chan.result_kind, rsp_chan.write_address,
                               rsp_chan.write_data);
      end
   end

   // Offers one byte, after a random number of idle cycles, and returns at the
   // edge where it transfers. Valid stays high on return so that back-to-back
   // bytes follow one another with no gap.
   task automatic send_byte(input logic [7:0] file_byte);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= file_byte;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // Words go out high byte first, as in the file.
   task automatic send_word(input logic [15:0] word);
      send_byte(word[15:8]);
      send_byte(word[7:0]);
   endtask

   task automatic send_random_bytes(input int count);
      for (int i = 0; i < count; i++) send_byte(8'($urandom));
   endtask

   // A line-number section is its header and three words that are skipped.
   task automatic send_line_section();
      send_word(HDR_LINE);
      send_random_bytes(int'(LINE_SKIP_BYTES));
   endtask

   // One well-formed section of random kind and content. Most counts are small
   // so that many sections fit; now and then a load section runs longer to
   // build up backpressure. Load addresses often sit near the top of the
   // address space so that the wrap is crossed.
   task automatic send_random_section();
      int          pick;
      int          count;
      logic [15:0] address;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         count   = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
         address = ($urandom_range(0, 3) == 0) ? 16'hFFF0 | 16'($urandom_range(0, 15))
                                               : 16'($urandom);
         send_word(($urandom_range(0, 1) == 0) ? HDR_CODE : HDR_DATA);
         send_word(address);
         send_word(16'(count));
         for (int i = 0; i < count; i++) send_word(16'($urandom));
      end else if (pick < 65) begin
         count = $urandom_range(0, 12);
         send_word(HDR_SYMBOL);
         send_word(16'($urandom));
         send_word(16'(count));
         send_random_bytes(count);
      end else if (pick < 80) begin
         count = $urandom_range(0, 12);
         send_word(HDR_FILENAME);
         send_word(16'(count));
         send_random_bytes(count);
      end else begin
         send_line_section();
      end
   endtask

   initial begin
      logic [15:0] bad_header;
      int          phase_end;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with no idling. A code section starts at the top
      // address so its second word wraps to zero, and it carries all-ones and
      // all-zeros data. A data section with zero count ends right after the
      // count word. A symbol section drops its address word and skips one
      // byte; its address must not disturb the load address. A filename
      // section skips one byte, and a line-number section skips three words.
      send_word(HDR_CODE);
      send_word(16'hFFFF);
      send_word(16'd2);
      send_word(16'hFFFF);
      send_word(16'h0000);
      send_word(HDR_DATA);
      send_word(16'h0000);
      send_word(16'h0000);
      send_word(HDR_SYMBOL);
      send_word(16'h1234);
      send_word(16'd1);
      send_byte(8'hA5);
      send_word(HDR_FILENAME);
      send_word(16'd1);
      send_byte(8'h5A);
      send_line_section();

      // Random part. A bad header halts the block for good, and reset is applied
      // only once, so every random section is well formed; the content, the
      // skipped bytes and the counts are what vary. The phases run with no
      // idling, a mostly idle source, a mostly stalled receiver, and both
      // sides idling a third of the time.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 82;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 82;
            end
            default: begin
               send_idle_pct  = 34;
               recv_stall_pct = 34;
            end
         endcase
         phase_end = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < phase_end) send_random_section();
      end

      // The file ends in an unknown header: one error result, and the bytes
      // that follow are taken and dropped.
      do bad_header = 16'($urandom);
      while (bad_header == HDR_CODE || bad_header == HDR_DATA ||
             bad_header == HDR_SYMBOL || bad_header == HDR_FILENAME ||
             bad_header == HDR_LINE);
      send_word(bad_header);
      send_random_bytes(4);
      req_chan.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0) begin
         $display("object_file_section_loader_core verification clean");
      end else begin
         $display("object_file_section_loader_core verification failed");
      end
      $finish;
   end

endmodule
